// File: rtl/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the chunked body decoder
// Phase codes, result kinds, the item and result structs and hex decoding.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [1:0] SKIP_LEN = 2'd2;

  typedef enum logic [2:0] {
    PH_DIGITS = 3'd0,
    PH_REST   = 3'd1,
    PH_DATA   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef logic [SIZE_BITS-1:0] size_t;

  // one input item
  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_of_message;
  } item_t;

  // one result item
  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] data_byte;
  } result_t;

  // decoder status seen by the top level
  typedef struct packed {
    phase_t phase;
    logic   res_valid;
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/cbd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_in_stage: input register
// Captures one item from the input channel and holds it until it is decoded.
// ----------------------------------------------------------------------------
module cbd_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cbd_pkg::item_t in_item,
  input  logic           proc,
  output logic           item_valid,
  output cbd_pkg::item_t item
);
  import cbd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // free slot, or the held item leaves this cycle
  assign in_tready = !valid_r || proc;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/cbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_step: framing state and per-byte decode
// Holds phase, size and byte counters; turns one byte into at most one result.
// ----------------------------------------------------------------------------
module cbd_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             proc,
  input  cbd_pkg::item_t   item,
  output cbd_pkg::result_t res,
  output cbd_pkg::status_t status
);
  import cbd_pkg::*;

  phase_t     phase_r, phase_nxt, ph;
  size_t      acc_r, acc_nxt, acc;
  size_t      rem_r, rem_nxt, rem, rem_dec;
  logic [1:0] skip_r, skip_nxt, skip, skip_dec;
  hex_t       hex;
  logic       is_lf, ovf, acc_zero, res_valid;

  // start of message restarts at a size line before the byte is handled
  always_comb begin
    ph   = item.start_of_message ? PH_DIGITS : phase_r;
    acc  = item.start_of_message ? '0 : acc_r;
    rem  = item.start_of_message ? '0 : rem_r;
    skip = item.start_of_message ? 2'd0 : skip_r;
  end

  assign hex      = hex_decode(item.body_byte);
  assign is_lf    = (item.body_byte == CHAR_LF);
  assign ovf      = (acc[SIZE_BITS-1 -: 4] != 4'd0);
  assign acc_zero = (acc == '0);
  assign rem_dec  = rem - size_t'(1);
  assign skip_dec = (skip != 2'd0) ? skip - 2'd1 : skip;

  // next state
  always_comb begin
    phase_nxt = ph;
    acc_nxt   = acc;
    rem_nxt   = rem;
    skip_nxt  = skip;
    case (ph)
      PH_DIGITS, PH_REST: begin
        if (ph == PH_DIGITS && hex.valid) begin
          if (ovf) begin
            phase_nxt = PH_ERROR;
          end else begin
            acc_nxt = {acc[SIZE_BITS-5:0], hex.value};
          end
        end else if (is_lf) begin
          if (acc_zero) begin
            phase_nxt = PH_DONE;
          end else begin
            rem_nxt   = acc;
            phase_nxt = PH_DATA;
          end
        end else begin
          phase_nxt = PH_REST;
        end
      end
      PH_DATA: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_SKIP;
          skip_nxt  = SKIP_LEN;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_nxt = PH_DIGITS;
          acc_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res_valid       = 1'b0;
    res.result_kind = KIND_DATA;
    res.data_byte   = 8'd0;
    case (ph)
      PH_DIGITS, PH_REST: begin
        if (ph == PH_DIGITS && hex.valid) begin
          if (ovf) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_ERROR;
          end
        end else if (is_lf && acc_zero) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_END;
        end
      end
      PH_DATA: begin
        res_valid     = 1'b1;
        res.data_byte = item.body_byte;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DIGITS;
      acc_r   <= '0;
      rem_r   <= '0;
      skip_r  <= 2'd0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign status.phase     = phase_r;
  assign status.res_valid = res_valid;

endmodule

// File: rtl/cbd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_out_reg: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module cbd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             proc,
  input  logic             res_valid,
  input  cbd_pkg::result_t res,
  output logic             out_tvalid,
  input  logic             out_tready,
  output cbd_pkg::result_t out_res
);
  import cbd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // decode an item only when the slot is free or emptied this cycle
  assign proc      = item_valid && (!valid_r || out_tready);
  assign valid_nxt = proc ? res_valid : (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

// File: rtl/chunked_body_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_body_decoder_top: HTTP chunked body decoder
// Strips chunk size lines and the two bytes after each chunk's data from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one body byte per item in in_tdata, with in_tuser set
//   on the first byte of a message to restart decoding at a size line.
//   Output channel out_*: one result per data byte, one end-of-message item
//   after a zero size line, or one error item when the size line overflows.
//   Framing bytes produce no result item.
//   Latency: two register stages (input register, then result register); a
//   byte's result is loaded into the result register once the result
//   register is free. Throughput: one byte per cycle while the receiver takes
//   results; the per-byte decode is a single pass between the two registers.
//   Reset (rst_n low, synchronous) empties both registers and leaves the
//   decoder waiting for a size line.
//   When the receiver stalls, the result register holds its item, the input
//   register takes one more byte, and then in_tready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module chunked_body_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] body_byte
  input  logic       in_tuser,   // [0] start_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [1:0] out_tuser   // [1:0] result_kind
);
  import cbd_pkg::*;

  item_t   in_item, item;
  logic    item_valid, proc;
  result_t res, out_res;
  status_t status;

  assign in_item.body_byte        = in_tdata;
  assign in_item.start_of_message = in_tuser;

  cbd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .proc       (proc),
    .item_valid (item_valid),
    .item       (item)
  );

  cbd_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .proc   (proc),
    .item   (item),
    .res    (res),
    .status (status)
  );

  cbd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .proc       (proc),
    .res_valid  (status.res_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.data_byte;
  assign out_tuser = out_res.result_kind;

`ifndef NO_ASSERTIONS
  // non-data results carry a zero byte
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tdata == 8'd0)
    else $error("non-data result with nonzero byte");

  // after end of message or error, nothing comes out until restart
  a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !item.start_of_message &&
    (status.phase == PH_DONE || status.phase == PH_ERROR) |-> !status.res_valid)
    else $error("result produced while stopped");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule
